// File: rtl/gbl_pkg.sv
// Shared types and constants for the separable blur core.
package gbl_pkg;

  localparam int TAP_W  = 16;
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int RAD_W  = 2;
  localparam int KW     = 3;
  localparam int ACC_W  = 27;
  localparam int ADDR_W = 5;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_TAP_CTR   = 3'd3;
  localparam logic [2:0] REG_TAP_ONE   = 3'd4;
  localparam logic [2:0] REG_TAP_TWO   = 3'd5;
  localparam logic [2:0] REG_TAP_THREE = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [RAD_W-1:0] radius;
    logic [TAP_W-1:0] tap_center;
    logic [TAP_W-1:0] tap_one;
    logic [TAP_W-1:0] tap_two;
    logic [TAP_W-1:0] tap_three;
  } gbl_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HTAP,
    ST_HWR,
    ST_CHK,
    ST_VRD,
    ST_VACC,
    ST_VOUT
  } gbl_state_t;

endpackage

// File: rtl/gbl_cfg_regs.sv
// APB-style configuration register bank.
module gbl_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output gbl_pkg::gbl_cfg_t          cfg,
  output logic                       restart
);

  gbl_pkg::gbl_cfg_t cfg_r, cfg_nxt;
  logic              wr_en;
  logic [2:0]        idx;
  logic              hit;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (wr_en) begin
      unique case (idx)
        gbl_pkg::REG_WIDTH: begin
          cfg_nxt.image_width = pwdata[gbl_pkg::DIM_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_HEIGHT: begin
          cfg_nxt.image_height = pwdata[gbl_pkg::DIM_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_RADIUS: begin
          cfg_nxt.radius = pwdata[gbl_pkg::RAD_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_TAP_CTR: begin
          cfg_nxt.tap_center = pwdata[gbl_pkg::TAP_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_TAP_ONE: begin
          cfg_nxt.tap_one = pwdata[gbl_pkg::TAP_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_TAP_TWO: begin
          cfg_nxt.tap_two = pwdata[gbl_pkg::TAP_W-1:0];
          hit = 1'b1;
        end
        gbl_pkg::REG_TAP_THREE: begin
          cfg_nxt.tap_three = pwdata[gbl_pkg::TAP_W-1:0];
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  assign restart = hit;

  always_comb begin
    unique case (idx)
      gbl_pkg::REG_WIDTH:     prdata = {21'd0, cfg_r.image_width};
      gbl_pkg::REG_HEIGHT:    prdata = {21'd0, cfg_r.image_height};
      gbl_pkg::REG_RADIUS:    prdata = {30'd0, cfg_r.radius};
      gbl_pkg::REG_TAP_CTR:   prdata = {16'd0, cfg_r.tap_center};
      gbl_pkg::REG_TAP_ONE:   prdata = {16'd0, cfg_r.tap_one};
      gbl_pkg::REG_TAP_TWO:   prdata = {16'd0, cfg_r.tap_two};
      gbl_pkg::REG_TAP_THREE: prdata = {16'd0, cfg_r.tap_three};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 11'd640;
      cfg_r.image_height <= 11'd480;
      cfg_r.radius       <= 2'd2;
      cfg_r.tap_center   <= 16'd24217;
      cfg_r.tap_one      <= 16'd16020;
      cfg_r.tap_two      <= 16'd4637;
      cfg_r.tap_three    <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/gbl_mac.sv
// Shared multiply-accumulate unit with round-to-nearest and 8-bit saturation.
module gbl_mac (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      clr,
  input  logic [gbl_pkg::TAP_W-1:0] tap,
  input  logic [gbl_pkg::PIX_W-1:0] data,
  output logic [gbl_pkg::PIX_W-1:0] result
);

  logic [gbl_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [gbl_pkg::ACC_W-1:0] prod;
  logic [gbl_pkg::ACC_W:0]   rnd;
  logic [11:0]               hi;

  assign prod = gbl_pkg::ACC_W'(tap * data);

  always_comb begin
    acc_nxt = acc_r;
    if (en) begin
      acc_nxt = clr ? prod : acc_r + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign rnd    = {1'b0, acc_r} + (gbl_pkg::ACC_W+1)'(32768);
  assign hi     = rnd[gbl_pkg::ACC_W:16];
  assign result = (|hi[11:8]) ? 8'hFF : hi[7:0];

endmodule

// File: rtl/gbl_row_store.sv
// Store of horizontally filtered rows, one write and one registered read port.
module gbl_row_store #(
  parameter int CW = 10,
  parameter int SW = 3,
  parameter int ROWS = 7
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [SW-1:0]             wslot,
  input  logic [CW-1:0]             wcol,
  input  logic [gbl_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [SW-1:0]             rslot,
  input  logic [CW-1:0]             rcol,
  output logic [gbl_pkg::PIX_W-1:0] rdata
);

  localparam int DEPTH = ROWS << CW;

  logic [gbl_pkg::PIX_W-1:0] mem [0:DEPTH-1];
  logic [gbl_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wslot, wcol}] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[{rslot, rcol}];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/separable_gaussian_blur_core.sv
// Separable blur core: horizontal pass, row store, vertical pass, output register.
// Each pixel transaction is accepted, then each horizontal value that it completes
// (at most one mid-row, up to R+1 at the row end) is accumulated over its taps and
// written, then readiness is checked, then a vertical result is formed (one read of
// the row store and one multiply-accumulate per tap); a drain costs the check and,
// if a result is due, the vertical pass. The shared multiply-accumulate unit and the
// one read port of the row store serialize this work. The next transaction is
// accepted while a result still waits in the output register. A configuration
// write restarts the frame; no clearing pass.
module separable_gaussian_blur_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_pixel_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_pixel_out,
  output logic                       out_frame_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int SW = $clog2(WIN_DEPTH);
  localparam int KW = gbl_pkg::KW;

  gbl_pkg::gbl_cfg_t  cfg;
  logic               restart;
  gbl_pkg::gbl_state_t state_r, state_nxt;

  // positions
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;
  logic [SW-1:0] out_slot_r, out_slot_nxt;
  logic          fdone_r, fdone_nxt;

  // per-transaction work registers
  logic [CW-1:0] c_r, c_nxt;
  logic [SW-1:0] hslot_r, hslot_nxt;
  logic [CW-1:0] x_r, x_nxt;
  logic [CW-1:0] xend_r, xend_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic [7:0] sh_r [0:WIN_DEPTH-1];

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_pix_r;
  logic       out_last_r;

  logic [CW:0]         w;
  logic [HW:0]         h;
  logic [1:0]          r;
  logic [KW-1:0]       r2;
  logic                acc_in;
  logic                out_free;
  logic                last_col;
  logic                h_go;
  logic                ready;
  logic [HW:0]         last_needed;
  logic [1:0]          tap_dist;
  logic [15:0]         tap;
  logic signed [CW+1:0] xx_s;
  logic [CW-1:0]       xx;
  logic [SW-1:0]       off;
  logic signed [HW+1:0] yy_s;
  logic [HW-1:0]       yy;
  logic signed [HW+1:0] dy_s;
  logic signed [SW+1:0] vs_s;
  logic [SW-1:0]       vslot;

  logic       mac_en, mac_clr;
  logic [7:0] mac_data, mac_res;
  logic       mem_we, mem_re;
  logic [7:0] mem_rdata;
  logic       out_load;

  gbl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // effective sizes
  always_comb begin
    if (cfg.image_width == '0) begin
      w = (CW+1)'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w = (CW+1)'(MAX_WIDTH);
    end else begin
      w = (CW+1)'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = (HW+1)'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h = (HW+1)'(MAX_HEIGHT);
    end else begin
      h = (HW+1)'(cfg.image_height);
    end
    r = (32'(cfg.radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg.radius;
  end

  assign r2       = {r, 1'b0};
  assign acc_in   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign last_col = ({1'b0, in_col_r} + (CW+1)'(1)) >= w;
  assign h_go     = last_col | (in_col_r >= CW'(r));

  always_comb begin
    last_needed = {1'b0, out_row_r} + (HW+1)'(r);
    if (last_needed > h - (HW+1)'(1)) begin
      last_needed = h - (HW+1)'(1);
    end
    ready = fdone_r | ({1'b0, in_row_r} > last_needed);
  end

  // tap weight by distance from center
  always_comb begin
    tap_dist = (k_r < {1'b0, r}) ? 2'({1'b0, r} - k_r) : 2'(k_r - {1'b0, r});
    case (tap_dist)
      2'd0:    tap = cfg.tap_center;
      2'd1:    tap = cfg.tap_one;
      2'd2:    tap = cfg.tap_two;
      default: tap = cfg.tap_three;
    endcase
  end

  // horizontal source: offset back from the newest pixel in the shift line
  always_comb begin
    xx_s = $signed({2'b00, x_r}) + $signed((CW+2)'(k_r)) - $signed((CW+2)'(r));
    if (xx_s < 0) begin
      xx = '0;
    end else if (xx_s > $signed({1'b0, w} - (CW+2)'(1))) begin
      xx = CW'(w - (CW+1)'(1));
    end else begin
      xx = xx_s[CW-1:0];
    end
    off = SW'(c_r - xx);
  end

  // vertical source row slot
  always_comb begin
    yy_s = $signed({2'b00, out_row_r}) + $signed((HW+2)'(k_r)) - $signed((HW+2)'(r));
    if (yy_s < 0) begin
      yy = '0;
    end else if (yy_s > $signed({1'b0, h} - (HW+2)'(1))) begin
      yy = HW'(h - (HW+1)'(1));
    end else begin
      yy = yy_s[HW-1:0];
    end
    dy_s = $signed({2'b00, yy}) - $signed({2'b00, out_row_r});
    vs_s = $signed({2'b00, out_slot_r}) + $signed(dy_s[SW+1:0]);
    if (vs_s < 0) begin
      vs_s = vs_s + $signed((SW+2)'(WIN_DEPTH));
    end else if (vs_s >= $signed((SW+2)'(WIN_DEPTH))) begin
      vs_s = vs_s - $signed((SW+2)'(WIN_DEPTH));
    end
    vslot = vs_s[SW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbl_pkg::ST_IDLE: begin
        if (acc_in) begin
          if (in_cmd == gbl_pkg::CMD_PIXEL && h_go) begin
            state_nxt = gbl_pkg::ST_HTAP;
          end else begin
            state_nxt = gbl_pkg::ST_CHK;
          end
        end
      end
      gbl_pkg::ST_HTAP: if (k_r == r2) state_nxt = gbl_pkg::ST_HWR;
      gbl_pkg::ST_HWR: begin
        state_nxt = (x_r == xend_r) ? gbl_pkg::ST_CHK : gbl_pkg::ST_HTAP;
      end
      gbl_pkg::ST_CHK: state_nxt = ready ? gbl_pkg::ST_VRD : gbl_pkg::ST_IDLE;
      gbl_pkg::ST_VRD: state_nxt = gbl_pkg::ST_VACC;
      gbl_pkg::ST_VACC: begin
        state_nxt = (k_r == r2) ? gbl_pkg::ST_VOUT : gbl_pkg::ST_VRD;
      end
      gbl_pkg::ST_VOUT: if (out_free) state_nxt = gbl_pkg::ST_IDLE;
      default: state_nxt = gbl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    mac_en   = 1'b0;
    mac_data = mem_rdata;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      gbl_pkg::ST_IDLE: in_stall = 1'b0;
      gbl_pkg::ST_HTAP: begin
        mac_en   = 1'b1;
        mac_data = sh_r[off];
      end
      gbl_pkg::ST_HWR:  mem_we = 1'b1;
      gbl_pkg::ST_CHK:  mac_en = 1'b0;
      gbl_pkg::ST_VRD:  mem_re = 1'b1;
      gbl_pkg::ST_VACC: mac_en = 1'b1;
      gbl_pkg::ST_VOUT: out_load = out_free;
      default:          in_stall = 1'b1;
    endcase
  end

  assign mac_clr = (k_r == '0);

  // datapath next values
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    fdone_nxt    = fdone_r;
    c_nxt        = c_r;
    hslot_nxt    = hslot_r;
    x_nxt        = x_r;
    xend_nxt     = xend_r;
    k_nxt        = k_r;
    if (restart) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      fdone_nxt    = 1'b0;
    end else begin
      case (state_r)
        gbl_pkg::ST_IDLE: begin
          k_nxt = '0;
          if (acc_in && in_cmd == gbl_pkg::CMD_PIXEL) begin
            // a new frame drops what is still pending from the last one
            if (fdone_r) begin
              out_col_nxt  = '0;
              out_row_nxt  = '0;
              out_slot_nxt = '0;
              fdone_nxt    = 1'b0;
            end
            c_nxt     = in_col_r;
            hslot_nxt = in_slot_r;
            xend_nxt  = last_col ? in_col_r : in_col_r - CW'(r);
            x_nxt     = (in_col_r >= CW'(r)) ? in_col_r - CW'(r) : '0;
            if (!last_col) begin
              in_col_nxt = in_col_r + CW'(1);
            end else begin
              in_col_nxt = '0;
              if (({1'b0, in_row_r} + (HW+1)'(1)) < h) begin
                in_row_nxt  = in_row_r + HW'(1);
                in_slot_nxt = (32'(in_slot_r) == WIN_DEPTH - 1) ? '0
                              : in_slot_r + SW'(1);
              end else begin
                in_row_nxt  = '0;
                in_slot_nxt = '0;
                fdone_nxt   = 1'b1;
              end
            end
          end
        end
        gbl_pkg::ST_HTAP: k_nxt = (k_r == r2) ? '0 : k_r + KW'(1);
        gbl_pkg::ST_HWR: begin
          if (x_r != xend_r) x_nxt = x_r + CW'(1);
        end
        gbl_pkg::ST_CHK:  k_nxt = '0;
        gbl_pkg::ST_VACC: k_nxt = k_r + KW'(1);
        gbl_pkg::ST_VOUT: begin
          if (out_free) begin
            if (({1'b0, out_col_r} + (CW+1)'(1)) < w) begin
              out_col_nxt = out_col_r + CW'(1);
            end else begin
              out_col_nxt = '0;
              if (({1'b0, out_row_r} + (HW+1)'(1)) < h) begin
                out_row_nxt  = out_row_r + HW'(1);
                out_slot_nxt = (32'(out_slot_r) == WIN_DEPTH - 1) ? '0
                               : out_slot_r + SW'(1);
              end else begin
                out_row_nxt  = '0;
                out_slot_nxt = '0;
                fdone_nxt    = 1'b0;
              end
            end
          end
        end
        default: k_nxt = k_r;
      endcase
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbl_pkg::ST_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      fdone_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_slot_r   <= in_slot_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_slot_r  <= out_slot_nxt;
      fdone_r     <= fdone_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    hslot_r <= hslot_nxt;
    x_r     <= x_nxt;
    xend_r  <= xend_nxt;
    if (out_load) begin
      out_pix_r  <= mac_res;
      out_last_r <= ({1'b0, out_row_r} == h - (HW+1)'(1))
                    && ({1'b0, out_col_r} == w - (CW+1)'(1));
    end
  end

  // newest raw pixel of the row at index 0
  always_ff @(posedge clk) begin
    if (acc_in && in_cmd == gbl_pkg::CMD_PIXEL && !restart) begin
      sh_r[0] <= in_pixel_in;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  gbl_mac u_mac (
    .clk    (clk),
    .en     (mac_en),
    .clr    (mac_clr),
    .tap    (tap),
    .data   (mac_data),
    .result (mac_res)
  );

  gbl_row_store #(
    .CW   (CW),
    .SW   (SW),
    .ROWS (WIN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .wslot (hslot_r),
    .wcol  (x_r),
    .wdata (mac_res),
    .re    (mem_re),
    .rslot (vslot),
    .rcol  (out_col_r),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

// File: rtl/gbl_checker.sv
// Port-level checker for the blur core, bound to the top level.
module gbl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_out,
  input logic       out_frame_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out)
                                && $stable(out_frame_last))
    else $error("stalled result changed");

  // results only appear while the input side is busy computing
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without computation");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind separable_gaussian_blur_core gbl_checker u_gbl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_out  (out_pixel_out),
  .out_frame_last (out_frame_last)
);

// File: sim/tb_top.sv
// Self-checking testbench for separable_gaussian_blur_core.
`timescale 1ns / 100ps

module tb_top;

  localparam int WMAX = 1024;
  localparam int HMAX = 1024;
  localparam int DEPTH = 7;
  localparam int LIMIT = 3000000;
  localparam int DRAIN_WAIT = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = gbl_pkg::CMD_PIXEL;
  logic [7:0] in_pixel_in = 8'd0;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_pixel_out;
  logic out_frame_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gbl_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  separable_gaussian_blur_core uut (.*);

  always #5 clk = ~clk;

  // ---------------- blur predictor ----------------
  logic [gbl_pkg::DIM_W-1:0] m_width, m_height;
  logic [gbl_pkg::RAD_W-1:0] m_radius;
  logic [gbl_pkg::TAP_W-1:0] m_tap [4];
  logic [7:0] m_window [DEPTH];
  logic [7:0] m_rows [DEPTH*WMAX];
  int m_in_col, m_in_row, m_out_col, m_out_row;
  bit m_in_done;

  typedef struct packed {
    logic [7:0] pix;
    logic last;
  } blur_res_t;
  blur_res_t blurred_q[$];

  function automatic logic [7:0] round_sat(longint unsigned acc);
    longint unsigned v;
    v = (acc + 32768) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic int clampi(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_w();
    return (m_width < 1) ? 1 : (m_width > WMAX ? WMAX : int'(m_width));
  endfunction

  function automatic int eff_h();
    return (m_height < 1) ? 1 : (m_height > HMAX ? HMAX : int'(m_height));
  endfunction

  function automatic void restart_frame();
    m_in_col = 0; m_in_row = 0; m_out_col = 0; m_out_row = 0; m_in_done = 0;
  endfunction

  function automatic void pred_cfg(int idx, logic [31:0] val);
    case (idx)
      gbl_pkg::REG_WIDTH:     m_width = val[gbl_pkg::DIM_W-1:0];
      gbl_pkg::REG_HEIGHT:    m_height = val[gbl_pkg::DIM_W-1:0];
      gbl_pkg::REG_RADIUS:    m_radius = val[gbl_pkg::RAD_W-1:0];
      gbl_pkg::REG_TAP_CTR:   m_tap[0] = val[15:0];
      gbl_pkg::REG_TAP_ONE:   m_tap[1] = val[15:0];
      gbl_pkg::REG_TAP_TWO:   m_tap[2] = val[15:0];
      gbl_pkg::REG_TAP_THREE: m_tap[3] = val[15:0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic void hfilter(int x, int w, int r);
    longint unsigned acc;
    int xx;
    acc = 0;
    for (int i = -r; i <= r; i++) begin
      xx = clampi(x + i, w - 1);
      acc += longint'(m_tap[i < 0 ? -i : i]) * m_window[xx % DEPTH];
    end
    m_rows[(m_in_row % DEPTH) * WMAX + x] = round_sat(acc);
  endfunction

  function automatic bit blur_step(logic cmd, logic [7:0] px, output blur_res_t res);
    int w, h, r, c, x, need, yy;
    longint unsigned acc;
    w = eff_w(); h = eff_h(); r = m_radius;
    if (cmd == gbl_pkg::CMD_PIXEL) begin
      if (m_in_done) begin
        m_out_col = 0; m_out_row = 0; m_in_done = 0;
      end
      c = m_in_col;
      m_window[c % DEPTH] = px;
      if (m_in_col + 1 < w) begin
        if (c >= r) hfilter(c - r, w, r);
        m_in_col++;
      end else begin
        for (x = (c >= r) ? c - r : 0; x <= c; x++) hfilter(x, w, r);
        m_in_col = 0;
        if (m_in_row + 1 < h) m_in_row++;
        else begin
          m_in_row = 0;
          m_in_done = 1;
        end
      end
    end
    need = (m_out_row + r > h - 1) ? h - 1 : m_out_row + r;
    if (!(m_in_done || m_in_row > need)) return 0;
    acc = 0;
    for (int j = -r; j <= r; j++) begin
      yy = clampi(m_out_row + j, h - 1);
      acc += longint'(m_tap[j < 0 ? -j : j]) * m_rows[(yy % DEPTH) * WMAX + m_out_col];
    end
    res.pix = round_sat(acc);
    res.last = (m_out_row == h - 1) && (m_out_col == w - 1);
    if (m_out_col + 1 < w) m_out_col++;
    else begin
      m_out_col = 0;
      if (m_out_row + 1 < h) m_out_row++;
      else begin
        m_out_row = 0;
        m_in_done = 0;
      end
    end
    return 1;
  endfunction

  // ---------------- monitor and checker ----------------
  int errors = 0;
  int n_taken = 0;
  int cycles = 0;
  bit row_known = 0;
  blur_res_t row_exp;

  always @(posedge clk) begin
    blur_res_t r, got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_taken++;
        if (blur_step(in_cmd, in_pixel_in, r)) blurred_q.push_back(row_known ? row_exp : r);
      end
      if (out_valid && !out_stall) begin
        got.pix = out_pixel_out;
        got.last = out_frame_last;
        if (blurred_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel %0d last %0b", $time, got.pix, got.last);
        end else begin
          r = blurred_q.pop_front();
          if (got.pix !== r.pix) begin
            errors++;
            $display("%0t: pixel_out exp %0d got %0d", $time, r.pix, got.pix);
          end
          if (got.last !== r.last) begin
            errors++;
            $display("%0t: frame_last exp %0b got %0b", $time, r.last, got.last);
          end
        end
      end
    end
  end

  // ---------------- receiver ----------------
  bit stall_rand = 0;
  bit hold_off = 0;
  assign out_stall = stall_rand | hold_off;

  initial begin
    int pct;
    pct = 0;
    forever begin
      @(negedge clk);
      if ((cycles % 300) == 0) pct = $urandom_range(0, 3) * 25;
      stall_rand = ($urandom_range(0, 99) < pct);
    end
  end

  // long hold-off so the core backs up and stalls its input
  initial begin
    wait (n_taken >= 400);
    @(negedge clk);
    hold_off = 1;
    for (int k = 0; k < 600; k++) @(negedge clk);
    hold_off = 0;
  end

  // ---------------- sender ----------------
  int burst_left = 0;

  task automatic send_item(logic cmd, logic [7:0] px, bit known = 0,
                           blur_res_t kexp = '0);
    int seen;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid = 0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    in_valid = 1;
    in_cmd = cmd;
    in_pixel_in = px;
    row_known = known;
    row_exp = kexp;
    seen = n_taken;
    do @(negedge clk); while (n_taken == seen);
    in_valid = 0;
  endtask

  task automatic cfg_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = gbl_pkg::ADDR_W'(idx * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    pred_cfg(idx, val);
  endtask

  task automatic settle();
    while (blurred_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_all(int w, int h, int r, int t0, int t1, int t2, int t3);
    cfg_write(gbl_pkg::REG_WIDTH, w);
    cfg_write(gbl_pkg::REG_HEIGHT, h);
    cfg_write(gbl_pkg::REG_RADIUS, r);
    cfg_write(gbl_pkg::REG_TAP_CTR, t0);
    cfg_write(gbl_pkg::REG_TAP_ONE, t1);
    cfg_write(gbl_pkg::REG_TAP_TWO, t2);
    cfg_write(gbl_pkg::REG_TAP_THREE, t3);
  endtask

  // directed rows; setup selects a register set applied before the row
  typedef struct packed {
    logic [1:0] setup;
    logic cmd;
    logic [7:0] pix;
    logic known;
    logic [7:0] ep;
    logic el;
  } dir_row_t;

  localparam logic [1:0] SET_ID = 2'd0, SET_SAT = 2'd1, SET_BIG = 2'd2, SET_KEEP = 2'd3;

  dir_row_t dir_tbl [] = '{
    '{SET_ID,   gbl_pkg::CMD_PIXEL, 8'd0,   1'b1, 8'd0,   1'b1},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd255, 1'b1, 8'd255, 1'b1},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'h5A,  1'b1, 8'h5A,  1'b1},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'hA5,  1'b1, 8'hA5,  1'b1},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'hFF,  1'b0, 8'd0,   1'b0},
    '{SET_SAT,  gbl_pkg::CMD_PIXEL, 8'd255, 1'b1, 8'd255, 1'b1},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd1,   1'b1, 8'd9,   1'b1},
    '{SET_BIG,  gbl_pkg::CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd17,  1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd128, 1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd64,  1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd1,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd99,  1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd250, 1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd5,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd77,  1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
    // another pixel of the new frame that the 77 pixel began before the old one was drained
    '{SET_KEEP, gbl_pkg::CMD_PIXEL, 8'd33,  1'b0, 8'd0,   1'b0},
    '{SET_KEEP, gbl_pkg::CMD_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0}
  };

  function automatic logic [15:0] rand_tap();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 24000));
    endcase
  endfunction

  // one random frame; sometimes cut short or left undrained
  task automatic run_frame(int w, int h, int r, ref int items);
    int n;
    bit cut;
    set_all(w | ($urandom_range(0, 1) << 11) << 20, h, r | ($urandom() & 32'hFFFF_FFFC),
            rand_tap(), rand_tap(), rand_tap(), rand_tap());
    if ($urandom_range(0, 9) == 0) cfg_write(7, $urandom());
    n = eff_w() * eff_h();
    cut = ($urandom_range(0, 7) == 0);
    if (cut) n = $urandom_range(1, n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(gbl_pkg::CMD_DRAIN, 8'($urandom()));
        items++;
      end
      send_item(gbl_pkg::CMD_PIXEL, 8'($urandom()));
      items++;
    end
    if (!cut && $urandom_range(0, 9) != 0) begin
      while (m_in_done) begin
        send_item(gbl_pkg::CMD_DRAIN, 8'($urandom()));
        items++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(gbl_pkg::CMD_DRAIN, 8'($urandom()));
        items++;
      end
    end else if ($urandom_range(0, 1) == 0) begin
      // one more pixel; after a full frame it starts the next frame over the pending outputs
      send_item(gbl_pkg::CMD_PIXEL, 8'($urandom()));
      items++;
    end
    settle();
  endtask

  initial begin
    int items;
    m_width = 11'd640; m_height = 11'd480; m_radius = 2'd2;
    m_tap[0] = 16'd24217; m_tap[1] = 16'd16020; m_tap[2] = 16'd4637; m_tap[3] = 16'd0;
    for (int i = 0; i < DEPTH; i++) m_window[i] = '0;
    for (int i = 0; i < DEPTH*WMAX; i++) m_rows[i] = '0;
    restart_frame();
    repeat (9) @(negedge clk);
    rst_n = 1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].setup != SET_KEEP) begin
        settle();
        case (dir_tbl[i].setup)
          SET_ID:  set_all(1, 1, 0, 65535, 0, 0, 0);
          SET_SAT: set_all(1, 1, 1, 65535, 65535, 65535, 65535);
          default: set_all(4, 3, 3, 20000, 12000, 5000, 1500);
        endcase
      end
      send_item(dir_tbl[i].cmd, dir_tbl[i].pix, dir_tbl[i].known,
                '{dir_tbl[i].ep, dir_tbl[i].el});
    end
    settle();

    items = 0;
    // zero sizes clamp to a single pixel
    run_frame(0, 0, 1, items);
    while (items < 1200) begin
      run_frame($urandom_range(1, 12), $urandom_range(1, 9), $urandom_range(0, 3), items);
    end
    settle();

    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
